// ----- hdl/staggered_servo_pulse_scheduler_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the staggered servo pulse scheduler checkers.
// Both macros sample on the rising edge of clk and are disabled during rst.
// ---------------------------------------------------------------------------
`ifndef STAGGERED_SERVO_PULSE_SCHEDULER_ASSERT_SVH
`define STAGGERED_SERVO_PULSE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define SSPSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo scheduler check failed");

// Next-cycle implication.
`define SSPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo scheduler check failed");

`endif

// ----- hdl/sspsc_pkg.sv -----
// ---------------------------------------------------------------------------
// sspsc_pkg
// Shared constants, codes and types of the staggered servo pulse scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspsc_pkg;

  localparam int CHANNELS  = 7;
  localparam int MID_PULSE = 1500;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SEL_W     = 3;   // channel field of a command
  localparam int WIDTH_W   = 16;  // pulse width, microseconds
  localparam int TIME_W    = 18;  // elapsed count and frame times
  localparam int PAD_W     = 14;
  localparam int LIMIT_W   = 32;
  localparam int REG_IDX_W = 3;
  localparam int OP_W      = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 32'd131073000;
  localparam logic [PAD_W-1:0]   PADDING_RESET = 14'd50;
  localparam logic [TIME_W-1:0]  ELAPSED_MAX   = {TIME_W{1'b1}};

  // Register index of start_padding; indexes below CHANNELS are limit registers.
  localparam logic [REG_IDX_W-1:0] REG_PADDING = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_SNAP,
    ST_SORT_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_TICK,
    ST_SCAN_INIT,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_FINISH
  } state_t;

  // Operands of the shared add / compare unit.
  typedef struct packed {
    logic [TIME_W-1:0] add_a;
    logic [TIME_W-1:0] add_b;
    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
  } unit_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              lt;
  } unit_rsp_t;

endpackage

// ----- hdl/sspsc_if.sv -----
// ---------------------------------------------------------------------------
// sspsc command and response channels
// Valid/ready channels carrying one command beat and one response beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sspsc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [sspsc_pkg::OP_W-1:0]     opcode;
  logic [sspsc_pkg::SEL_W-1:0]    channel;
  logic [sspsc_pkg::WIDTH_W-1:0]  width;

  modport source (output valid, output opcode, output channel, output width,
                  input ready);
  modport sink   (input valid, input opcode, input channel, input width,
                  output ready);
endinterface

interface sspsc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sspsc_pkg::CHANNELS-1:0]  pin_levels;
  logic [sspsc_pkg::WIDTH_W-1:0]   width_readback;
  logic                            busy_res;

  modport source (output valid, output pin_levels, output width_readback,
                  output busy_res, input ready);
  modport sink   (input valid, input pin_levels, input width_readback,
                  input busy_res, output ready);
endinterface

// ----- hdl/staggered_servo_pulse_scheduler.sv -----
// ---------------------------------------------------------------------------
// staggered_servo_pulse_scheduler
// Seven-channel servo pulse generator with staggered, width-ranked starts.
// ---------------------------------------------------------------------------
// Every command beat yields exactly one response beat. A set command clamps
// the width to the channel's min/max register (min wins when min > max and
// the width is below it, max otherwise) and stores it. A start command, when
// no frame runs, snapshots the widths and ranks them by a selection sort;
// tick commands, one per microsecond, advance the frame: the channel of rank
// r is high from r*start_padding until r*start_padding plus its width, and
// busy_res drops once the last channel has fallen. All arithmetic goes
// through one shared 18-bit adder and one comparator stepped by a small
// sequencer, and the command channel stays not-ready while an item is in
// work. An item passes the accept step, a scan setup step, a scan of three
// steps per channel that builds the pin mask and the frame end, and a finish
// step that waits until the output register is free; a live tick adds one
// count step and a set on a real channel two clamp steps. A start that opens
// a frame adds a snapshot step and a selection sort of 21 compare steps and
// two swap steps per rank. A finished response waits in the output register
// while the next command is taken. No clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module staggered_servo_pulse_scheduler (
  input  logic                                clk,
  input  logic                                rst,
  sspsc_cmd_if.sink                           cmd,
  sspsc_rsp_if.source                         rsp,
  input  logic                                cfg_we,
  input  logic [sspsc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [sspsc_pkg::LIMIT_W-1:0]       cfg_data
);

  localparam int CH   = sspsc_pkg::CHANNELS;
  localparam int CW   = sspsc_pkg::CH_W;
  localparam int WW   = sspsc_pkg::WIDTH_W;
  localparam int TW   = sspsc_pkg::TIME_W;
  localparam logic [CW-1:0] LAST      = CW'(CH - 1);
  localparam logic [CW-1:0] SORT_LAST = CW'((CH > 1) ? CH - 2 : 0);

  sspsc_pkg::state_t state, state_next;

  // Configuration registers.
  logic [sspsc_pkg::LIMIT_W-1:0] limits [CH];
  logic [sspsc_pkg::PAD_W-1:0]   padding;

  // Channel state.
  logic [WW-1:0] stored_widths [CH];
  logic [WW-1:0] frame_widths  [CH];
  logic [CW-1:0] rank_order    [CH];
  logic [TW-1:0] elapsed;
  logic          active;

  // Latched command.
  logic [sspsc_pkg::SEL_W-1:0] ch_q;
  logic [WW-1:0]            w_q;
  logic                     upd_q;   // this item may change active

  // Sequencer working registers.
  logic [CW-1:0] sort_i, sort_j, least, scan_r, rd_addr;
  logic [WW-1:0] least_w;
  logic [CW-1:0] least_r;
  logic          below;
  logic [TW-1:0] rise, fall, fend;
  logic [CH-1:0] mask;

  // Output register.
  logic          out_valid;
  logic [CH-1:0] out_pins;
  logic [WW-1:0] out_readback;
  logic          out_busy;

  logic          ch_ok;
  logic [WW-1:0] lim_lo, lim_hi, rd_w;
  logic [CW-1:0] rd_r;
  logic          accept, go, act_final;

  sspsc_pkg::unit_req_t u_req;
  sspsc_pkg::unit_rsp_t u_rsp;

  sspsc_unit u_unit (
    .req (u_req),
    .rsp (u_rsp)
  );

  assign cmd.ready = (state == sspsc_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign go        = !out_valid || rsp.ready;

  assign ch_ok  = (ch_q < sspsc_pkg::SEL_W'(CH));
  assign lim_lo = limits[ch_q[CW-1:0]][WW-1:0];
  assign lim_hi = limits[ch_q[CW-1:0]][2*WW-1:WW];

  // Single read port into the frame snapshot.
  assign rd_w = frame_widths[rd_addr];
  assign rd_r = rank_order[rd_addr];

  // Activity after this item: frame-opening starts and live ticks compare the count
  // against the recomputed frame end; everything else keeps the flag.
  assign act_final = upd_q ? u_rsp.lt : active;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      sspsc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          unique case (sspsc_pkg::op_t'(cmd.opcode))
            sspsc_pkg::OP_SET: begin
              state_next = (cmd.channel < sspsc_pkg::SEL_W'(CH))
                           ? sspsc_pkg::ST_CLAMP_LO : sspsc_pkg::ST_SCAN_INIT;
            end
            sspsc_pkg::OP_START: begin
              state_next = active ? sspsc_pkg::ST_SCAN_INIT : sspsc_pkg::ST_SNAP;
            end
            sspsc_pkg::OP_TICK: begin
              state_next = active ? sspsc_pkg::ST_TICK : sspsc_pkg::ST_SCAN_INIT;
            end
            sspsc_pkg::OP_NOP: begin
              state_next = sspsc_pkg::ST_SCAN_INIT;
            end
          endcase
        end
      end
      sspsc_pkg::ST_CLAMP_LO: state_next = sspsc_pkg::ST_CLAMP_HI;
      sspsc_pkg::ST_CLAMP_HI: state_next = sspsc_pkg::ST_SCAN_INIT;
      sspsc_pkg::ST_SNAP: begin
        state_next = (CH > 1) ? sspsc_pkg::ST_SORT_CMP : sspsc_pkg::ST_SCAN_INIT;
      end
      sspsc_pkg::ST_SORT_CMP: begin
        if (sort_j == LAST) state_next = sspsc_pkg::ST_SWAP_A;
      end
      sspsc_pkg::ST_SWAP_A: state_next = sspsc_pkg::ST_SWAP_B;
      sspsc_pkg::ST_SWAP_B: begin
        state_next = (sort_i == SORT_LAST) ? sspsc_pkg::ST_SCAN_INIT
                                           : sspsc_pkg::ST_SORT_CMP;
      end
      sspsc_pkg::ST_TICK:      state_next = sspsc_pkg::ST_SCAN_INIT;
      sspsc_pkg::ST_SCAN_INIT: state_next = sspsc_pkg::ST_SCAN_A;
      sspsc_pkg::ST_SCAN_A:    state_next = sspsc_pkg::ST_SCAN_B;
      sspsc_pkg::ST_SCAN_B:    state_next = sspsc_pkg::ST_SCAN_C;
      sspsc_pkg::ST_SCAN_C: begin
        state_next = (scan_r == LAST) ? sspsc_pkg::ST_FINISH : sspsc_pkg::ST_SCAN_A;
      end
      sspsc_pkg::ST_FINISH: begin
        if (go) state_next = sspsc_pkg::ST_IDLE;
      end
      default: state_next = sspsc_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------- unit operands and reads
  always_comb begin
    u_req.add_a = rise;
    u_req.add_b = TW'(rd_w);
    u_req.cmp_a = elapsed;
    u_req.cmp_b = rise;
    rd_addr     = scan_r;
    unique case (state)
      sspsc_pkg::ST_CLAMP_LO: begin
        // width below min?
        u_req.cmp_a = TW'(w_q);
        u_req.cmp_b = TW'(lim_lo);
      end
      sspsc_pkg::ST_CLAMP_HI: begin
        // width above max?
        u_req.cmp_a = TW'(lim_hi);
        u_req.cmp_b = TW'(w_q);
      end
      sspsc_pkg::ST_SORT_CMP: begin
        rd_addr     = sort_j;
        u_req.cmp_a = TW'(rd_w);
        u_req.cmp_b = TW'(least_w);
      end
      sspsc_pkg::ST_SWAP_A: begin
        rd_addr = sort_i;
      end
      sspsc_pkg::ST_SWAP_B: begin
        rd_addr = sort_i + CW'(1);
      end
      sspsc_pkg::ST_TICK: begin
        u_req.add_a = elapsed;
        u_req.add_b = TW'(1);
      end
      sspsc_pkg::ST_SCAN_A: begin
        // fall = rise + width; not yet risen when elapsed < rise
        u_req.add_a = rise;
        u_req.add_b = TW'(rd_w);
        u_req.cmp_a = elapsed;
        u_req.cmp_b = rise;
      end
      sspsc_pkg::ST_SCAN_B: begin
        // next rise; still high when elapsed < fall
        u_req.add_a = rise;
        u_req.add_b = TW'(padding);
        u_req.cmp_a = elapsed;
        u_req.cmp_b = fall;
      end
      sspsc_pkg::ST_SCAN_C: begin
        u_req.cmp_a = fend;
        u_req.cmp_b = fall;
      end
      sspsc_pkg::ST_FINISH: begin
        u_req.cmp_a = elapsed;
        u_req.cmp_b = fend;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sspsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // -------------------------------------------------------- configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CH; k++) limits[k] <= sspsc_pkg::LIMIT_RESET;
      padding <= sspsc_pkg::PADDING_RESET;
    end else if (cfg_we) begin
      if (cfg_index < sspsc_pkg::REG_IDX_W'(CH)) begin
        limits[cfg_index[CW-1:0]] <= cfg_data;
      end else if (cfg_index == sspsc_pkg::REG_PADDING) begin
        padding <= cfg_data[sspsc_pkg::PAD_W-1:0];
      end
    end
  end

  // ----------------------------------------------- stored widths, frame status
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CH; k++) stored_widths[k] <= WW'(sspsc_pkg::MID_PULSE);
      elapsed <= '0;
      active  <= 1'b0;
    end else begin
      // Clamp: below min gives min, else above max gives max.
      if (state == sspsc_pkg::ST_CLAMP_HI) begin
        stored_widths[ch_q[CW-1:0]] <= below    ? lim_lo :
                                       u_rsp.lt ? lim_hi : w_q;
      end
      if (state == sspsc_pkg::ST_SNAP) begin
        elapsed <= '0;
      end else if (state == sspsc_pkg::ST_TICK && elapsed != sspsc_pkg::ELAPSED_MAX) begin
        elapsed <= u_rsp.sum;
      end
      if (state == sspsc_pkg::ST_FINISH && go && upd_q) begin
        active <= u_rsp.lt;
      end
    end
  end

  // ------------------------------------------------ command latch and sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q  <= cmd.channel;
      w_q   <= cmd.width;
      upd_q <= (sspsc_pkg::op_t'(cmd.opcode) == sspsc_pkg::OP_START && !active) ||
               (sspsc_pkg::op_t'(cmd.opcode) == sspsc_pkg::OP_TICK && active);
    end

    unique case (state)
      sspsc_pkg::ST_CLAMP_LO: begin
        below <= u_rsp.lt;
      end
      sspsc_pkg::ST_SNAP: begin
        // Snapshot widths and seed ranks with the channel numbers.
        for (int k = 0; k < CH; k++) begin
          frame_widths[k] <= stored_widths[k];
          rank_order[k]   <= CW'(k);
        end
        sort_i  <= '0;
        sort_j  <= CW'(1);
        least   <= '0;
        least_w <= stored_widths[0];
        least_r <= '0;
      end
      sspsc_pkg::ST_SORT_CMP: begin
        // Strict less-than keeps the earliest of equal widths.
        if (u_rsp.lt) begin
          least   <= sort_j;
          least_w <= rd_w;
          least_r <= rd_r;
        end
        sort_j <= sort_j + CW'(1);
      end
      sspsc_pkg::ST_SWAP_A: begin
        // Move the entry at rank i to the slot of the minimum.
        frame_widths[least] <= rd_w;
        rank_order[least]   <= rd_r;
      end
      sspsc_pkg::ST_SWAP_B: begin
        // Drop the minimum into rank i and open the next pass.
        frame_widths[sort_i] <= least_w;
        rank_order[sort_i]   <= least_r;
        sort_i  <= sort_i + CW'(1);
        sort_j  <= sort_i + CW'(2);
        least   <= sort_i + CW'(1);
        least_w <= rd_w;
        least_r <= rd_r;
      end
      sspsc_pkg::ST_SCAN_INIT: begin
        scan_r <= '0;
        rise   <= '0;
        fend   <= '0;
        mask   <= '0;
      end
      sspsc_pkg::ST_SCAN_A: begin
        fall  <= u_rsp.sum;
        below <= u_rsp.lt;
      end
      sspsc_pkg::ST_SCAN_B: begin
        if (!below && u_rsp.lt && rd_r <= LAST) mask[rd_r] <= 1'b1;
        rise <= u_rsp.sum;
      end
      sspsc_pkg::ST_SCAN_C: begin
        if (u_rsp.lt) fend <= fall;
        scan_r <= scan_r + CW'(1);
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ response beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sspsc_pkg::ST_FINISH && go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sspsc_pkg::ST_FINISH && go) begin
      out_pins     <= act_final ? mask : '0;
      out_readback <= ch_ok ? stored_widths[ch_q[CW-1:0]] : '0;
      out_busy     <= act_final;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.pin_levels     = out_pins;
  assign rsp.width_readback = out_readback;
  assign rsp.busy_res       = out_busy;

endmodule

// ----- hdl/sspsc_unit.sv -----
// ---------------------------------------------------------------------------
// sspsc_unit
// Shared adder and magnitude comparator reused across the sequencer steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspsc_unit (
  input  sspsc_pkg::unit_req_t req,
  output sspsc_pkg::unit_rsp_t rsp
);

  // Frame times stay below 2^18, so the carry out is never needed.
  assign rsp.sum = req.add_a + req.add_b;
  assign rsp.lt  = (req.cmp_a < req.cmp_b);

endmodule

// ----- hdl/sspsc_checker.sv -----
// ---------------------------------------------------------------------------
// sspsc_checker
// Port-level checks of the scheduler, bound onto the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "staggered_servo_pulse_scheduler_assert.svh"

module sspsc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [sspsc_pkg::CHANNELS-1:0]     rsp_pins,
  input logic [sspsc_pkg::WIDTH_W-1:0]      rsp_readback,
  input logic                               rsp_busy
);

  // Whole response payload, so one stability check covers it.
  logic [sspsc_pkg::CHANNELS+sspsc_pkg::WIDTH_W:0] rsp_beat;

  assign rsp_beat = {rsp_pins, rsp_readback, rsp_busy};

  // A pin can only be high inside a running frame.
  `SSPSC_ASSERT_NOW(a_pins_need_busy, rsp_valid && rsp_pins != '0, rsp_busy)

  // A command stays in work after its accept: no back-to-back accept.
  `SSPSC_ASSERT_NEXT(a_cmd_multicycle, cmd_valid && cmd_ready, !cmd_ready)

  // A stalled response beat holds.
  `SSPSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))

endmodule

bind staggered_servo_pulse_scheduler sspsc_checker u_sspsc_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_pins     (rsp.pin_levels),
  .rsp_readback (rsp.width_readback),
  .rsp_busy     (rsp.busy_res)
);

// ----- verif/staggered_servo_pulse_scheduler_test.sv -----
// ---------------------------------------------------------------------------
// staggered_servo_pulse_scheduler_test
// Self-checking bench for the staggered servo pulse scheduler. A driver takes
// command beats from a backlog and offers them on the command channel. A
// behavioral scheduler model predicts the response of each accepted beat:
// clamping, ranked frame snapshot, pin levels and busy. A monitor compares
// each response beat, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module staggered_servo_pulse_scheduler_test;

  localparam int CHANNELS  = sspsc_pkg::CHANNELS;
  localparam int SEL_W     = sspsc_pkg::SEL_W;
  localparam int WIDTH_W   = sspsc_pkg::WIDTH_W;
  localparam int TIME_W    = sspsc_pkg::TIME_W;
  localparam int PAD_W     = sspsc_pkg::PAD_W;
  localparam int LIMIT_W   = sspsc_pkg::LIMIT_W;
  localparam int REG_IDX_W = sspsc_pkg::REG_IDX_W;

  // Cycles with no beat and no register write before the run is declared hung.
  // The longest legal quiet stretch is the response hold-off plus one
  // start item.
  localparam int STALL_LIMIT   = 4000;
  // Quiet cycles after the last response before touching registers: more
  // than the slowest item, so nothing can still be in work.
  localparam int SETTLE_CYCLES = 80;
  // Response-side hold-off: starts once this many commands are in, lasts this long.
  localparam int HOLDOFF_AT    = 400;
  localparam int HOLDOFF_LEN   = 600;
  // Window of accepted commands in which neither side idles.
  localparam int STEADY_FROM   = 800;
  localparam int STEADY_TO     = 1000;

  typedef struct packed {
    sspsc_pkg::op_t     opcode;
    logic [SEL_W-1:0]   channel;
    logic [WIDTH_W-1:0] width;
  } command_t;

  typedef struct packed {
    logic [CHANNELS-1:0] pins;
    logic [WIDTH_W-1:0]  readback;
    logic                busy;
  } response_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;

  sspsc_cmd_if cmd_ch ();
  sspsc_rsp_if rsp_ch ();

  staggered_servo_pulse_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // -------------------------------------------------------------------------
  // Scheduler model state: its own copy of the registers and of the frame.
  // -------------------------------------------------------------------------
  logic [LIMIT_W-1:0] ch_limits   [CHANNELS];
  logic [PAD_W-1:0]   pad_us;
  logic [WIDTH_W-1:0] held_width  [CHANNELS];
  logic [WIDTH_W-1:0] snap_width  [CHANNELS];
  logic [2:0]         snap_rank   [CHANNELS];
  logic [TIME_W-1:0]  elapsed_us;
  bit                 frame_on;

  command_t  command_backlog [$];   // beats waiting for the driver
  response_t awaited_responses [$]; // predictions, oldest first

  int items_queued;       // beats handed to the backlog so far
  int responses_checked;  // response beats seen by the monitor
  int cmds_taken;         // command beats accepted by the block
  int mismatches;
  int idle_cycles;
  int holdoff_left;
  bit holdoff_done;
  bit steady;

  // Both sides run without random idling inside this window.
  assign steady = (cmds_taken >= STEADY_FROM) && (cmds_taken < STEADY_TO);

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w,
                                                     input logic [LIMIT_W-1:0] lim);
    logic [WIDTH_W-1:0] lo;
    logic [WIDTH_W-1:0] hi;
    lo = lim[15:0];
    hi = lim[31:16];
    // Min is checked first, so with min above max a low width lands on min.
    if (w < lo) return lo;
    if (w > hi) return hi;
    return w;
  endfunction

  // Time at which the last ranked pulse falls; uses the live padding.
  function automatic int frame_finish();
    int latest;
    int e;
    latest = 0;
    for (int r = 0; r < CHANNELS; r++) begin
      e = r * int'(pad_us) + int'(snap_width[r]);
      if (e > latest) latest = e;
    end
    return latest;
  endfunction

  function automatic logic [CHANNELS-1:0] pin_state();
    logic [CHANNELS-1:0] levels;
    int rise;
    int fall;
    levels = '0;
    if (frame_on) begin
      for (int r = 0; r < CHANNELS; r++) begin
        rise = r * int'(pad_us);
        fall = rise + int'(snap_width[r]);
        if (int'(elapsed_us) >= rise && int'(elapsed_us) < fall)
          levels[snap_rank[r]] = 1'b1;
      end
    end
    return levels;
  endfunction

  task automatic reset_scheduler_model();
    for (int i = 0; i < CHANNELS; i++) begin
      ch_limits[i]  = sspsc_pkg::LIMIT_RESET;
      held_width[i] = WIDTH_W'(sspsc_pkg::MID_PULSE);
      snap_width[i] = '0;
      snap_rank[i]  = '0;
    end
    pad_us     = sspsc_pkg::PADDING_RESET;
    elapsed_us = '0;
    frame_on   = 1'b0;
  endtask

  // Snapshot the stored widths and rank them: selection sort, strict less-than,
  // swap only when a smaller entry turns up, the same ranking the block builds.
  task automatic open_frame();
    int least;
    logic [WIDTH_W-1:0] tw;
    logic [2:0] tr;
    for (int i = 0; i < CHANNELS; i++) begin
      snap_width[i] = held_width[i];
      snap_rank[i]  = 3'(i);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      least = i;
      for (int j = i; j < CHANNELS; j++)
        if (snap_width[j] < snap_width[least]) least = j;
      if (least != i) begin
        tw = snap_width[i];
        tr = snap_rank[i];
        snap_width[i]     = snap_width[least];
        snap_rank[i]      = snap_rank[least];
        snap_width[least] = tw;
        snap_rank[least]  = tr;
      end
    end
    elapsed_us = '0;
    // A frame with all widths and the padding at zero never goes busy.
    frame_on = (frame_finish() > 0);
  endtask

  // Advance the model by one accepted beat and queue the response it implies.
  task automatic apply_command(input command_t c);
    response_t r;
    bit known;
    known = (c.channel < CHANNELS);
    case (c.opcode)
      sspsc_pkg::OP_SET: begin
        // Out-of-range channel: drop the write.
        if (known) held_width[c.channel] = clamp_width(c.width, ch_limits[c.channel]);
      end
      sspsc_pkg::OP_START: begin
        // Start while busy: ignore.
        if (!frame_on) open_frame();
      end
      sspsc_pkg::OP_TICK: begin
        // Tick while idle: nothing moves.
        if (frame_on) begin
          if (elapsed_us != sspsc_pkg::ELAPSED_MAX) elapsed_us = elapsed_us + 1'b1;
          frame_on = (int'(elapsed_us) < frame_finish());
        end
      end
      default: ;  // no-op still answers
    endcase
    r.pins     = pin_state();
    r.readback = known ? held_width[c.channel] : '0;
    r.busy     = frame_on;
    awaited_responses.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: response %0d %s: got 0x%0h, want 0x%0h",
             responses_checked, what, got, want);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: offer backlog beats, hold a beat until it is taken, idle at random.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    command_t nxt;
    command_t taken;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmds_taken   <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        taken.opcode  = sspsc_pkg::op_t'(cmd_ch.opcode);
        taken.channel = cmd_ch.channel;
        taken.width   = cmd_ch.width;
        apply_command(taken);
        cmds_taken <= cmds_taken + 1;
      end
      // Hold a pending beat; otherwise pick the next one or idle.
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (command_backlog.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
          nxt = command_backlog.pop_front();
          cmd_ch.valid   <= 1'b1;
          cmd_ch.opcode  <= nxt.opcode;
          cmd_ch.channel <= nxt.channel;
          cmd_ch.width   <= nxt.width;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Response ready: random idling plus one long hold-off, counted here, so the
  // block fills up and backs up the command channel.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && cmds_taken >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      rsp_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check each response beat against the oldest prediction.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    response_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("arrived with nothing awaited", rsp_ch.pin_levels, 0);
      end else begin
        want = awaited_responses.pop_front();
        if (rsp_ch.pin_levels !== want.pins)
          report_mismatch("pin_levels", rsp_ch.pin_levels, want.pins);
        if (rsp_ch.width_readback !== want.readback)
          report_mismatch("width_readback", rsp_ch.width_readback, want.readback);
        if (rsp_ch.busy_res !== want.busy)
          report_mismatch("busy_res", rsp_ch.busy_res, want.busy);
      end
      responses_checked <= responses_checked + 1;
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_command(input sspsc_pkg::op_t op, input int ch, input int w);
    command_t c;
    c.opcode  = op;
    c.channel = ch[SEL_W-1:0];
    c.width   = w[WIDTH_W-1:0];
    command_backlog.push_back(c);
    items_queued++;
  endtask

  // Mostly real channels, now and then the unused index 7.
  function automatic int pick_channel();
    return ($urandom_range(99) < 10) ? 7 : $urandom_range(0, CHANNELS - 1);
  endfunction

  // Half full-range widths, half near the narrow limits used in random phases.
  function automatic int pick_width();
    return ($urandom_range(1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 50);
  endfunction

  // Write one register and mirror it in the model; block must be idle.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [LIMIT_W-1:0] value);
    if (idx < CHANNELS) ch_limits[idx] = value;
    else if (idx == sspsc_pkg::REG_PADDING) pad_us = value[PAD_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_responses();
    while (responses_checked < items_queued) @(posedge clk);
  endtask

  // Pause the sender until every response is in, run any open frame to its
  // end, then let the block go fully quiet before registers change.
  task automatic settle();
    int left;
    wait_responses();
    if (frame_on) begin
      left = frame_finish() - int'(elapsed_us);
      repeat (left) queue_command(sspsc_pkg::OP_TICK, pick_channel(), $urandom);
      wait_responses();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Narrow random limits keep frames short; min above max shows up often.
  task automatic write_random_limits(input int pad_lo, input int pad_hi);
    logic [15:0] lo;
    logic [15:0] hi;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      lo = 16'($urandom_range(0, 30));
      hi = 16'($urandom_range(0, 45));
      write_register(REG_IDX_W'(ch), {hi, lo});
    end
    write_register(sspsc_pkg::REG_PADDING, LIMIT_W'($urandom_range(pad_lo, pad_hi)));
  endtask

  // Mostly well-formed frames: a few sets, a start, a run of ticks with the
  // odd stray command mixed in. The rest is random noise.
  task automatic queue_random_phase(input int budget);
    int queued;
    int n;
    int t;
    queued = 0;
    while (queued < budget) begin
      if ($urandom_range(99) < 75) begin
        n = $urandom_range(0, 7);
        repeat (n) queue_command(sspsc_pkg::OP_SET, pick_channel(), pick_width());
        queue_command(sspsc_pkg::OP_START, pick_channel(), $urandom);
        t = $urandom_range(0, 90);
        repeat (t) begin
          if ($urandom_range(99) < 8)
            queue_command(sspsc_pkg::op_t'($urandom_range(0, 3)), pick_channel(),
                          pick_width());
          else
            queue_command(sspsc_pkg::OP_TICK, pick_channel(), $urandom);
        end
        queued += n + 1 + t;
      end else begin
        repeat (5) queue_command(sspsc_pkg::op_t'($urandom_range(0, 3)), pick_channel(),
                                 pick_width());
        queued += 5;
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = sspsc_pkg::OP_NOP;
    cmd_ch.channel    = '0;
    cmd_ch.width      = '0;
    rsp_ch.ready      = 1'b0;
    items_queued      = 0;
    responses_checked = 0;
    mismatches        = 0;
    reset_scheduler_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset limits (1000..2000): clamp both ends, unused channel, no-op,
    // tick with no frame running.
    queue_command(sspsc_pkg::OP_SET,  0, 0);
    queue_command(sspsc_pkg::OP_SET,  1, 65535);
    queue_command(sspsc_pkg::OP_SET,  2, 1500);
    queue_command(sspsc_pkg::OP_SET,  7, 1234);
    queue_command(sspsc_pkg::OP_NOP,  3, 0);
    queue_command(sspsc_pkg::OP_TICK, 6, 0);
    queue_command(sspsc_pkg::OP_NOP,  7, 65535);
    settle();

    // Narrow limits, one channel with min above max, one pinned to zero.
    for (int ch = 0; ch < CHANNELS; ch++)
      write_register(REG_IDX_W'(ch), {16'd20, 16'd2});
    write_register(REG_IDX_W'(3), {16'd5, 16'd15});
    write_register(REG_IDX_W'(6), '0);
    write_register(sspsc_pkg::REG_PADDING, LIMIT_W'(1));
    queue_command(sspsc_pkg::OP_SET, 0, 0);      // below min
    queue_command(sspsc_pkg::OP_SET, 1, 65535);  // above max
    queue_command(sspsc_pkg::OP_SET, 2, 10);
    queue_command(sspsc_pkg::OP_SET, 3, 3);      // min above max, below min
    queue_command(sspsc_pkg::OP_SET, 4, 9);
    queue_command(sspsc_pkg::OP_SET, 5, 10);     // tie with channel 2
    queue_command(sspsc_pkg::OP_SET, 6, 100);    // clamps to zero
    queue_command(sspsc_pkg::OP_SET, 3, 15);     // min above max, not below min
    queue_command(sspsc_pkg::OP_START, 0, 0);
    queue_command(sspsc_pkg::OP_TICK, 1, 0);
    queue_command(sspsc_pkg::OP_START, 2, 0);    // busy: ignored
    queue_command(sspsc_pkg::OP_SET, 2, 7);      // frame keeps its snapshot
    repeat (8) queue_command(sspsc_pkg::OP_TICK, pick_channel(), 0);
    settle();

    // All-ones limits (min = max = 65535) and a padding of 10000: every width reads back as the max.
    for (int ch = 0; ch < CHANNELS; ch++)
      write_register(REG_IDX_W'(ch), '1);
    write_register(sspsc_pkg::REG_PADDING, LIMIT_W'(10000));
    for (int ch = 0; ch < CHANNELS; ch++)
      queue_command(sspsc_pkg::OP_SET, ch, (ch == 0) ? 0 : pick_width());
    queue_command(sspsc_pkg::OP_TICK, 4, 0);
    settle();

    // Zero limits: every width collapses to zero, so a start gives an empty frame.
    for (int ch = 0; ch < CHANNELS; ch++)
      write_register(REG_IDX_W'(ch), '0);
    for (int ch = 0; ch < CHANNELS; ch++)
      queue_command(sspsc_pkg::OP_SET, ch, 65535);
    queue_command(sspsc_pkg::OP_START, 5, 0);
    queue_command(sspsc_pkg::OP_TICK, 5, 0);
    settle();

    // Random phases across several register settings, padding extremes included.
    write_random_limits(0, 0);
    queue_random_phase(250);
    settle();
    write_random_limits(1, 12);
    queue_random_phase(250);
    settle();
    write_random_limits(12, 12);
    queue_random_phase(250);
    settle();
    write_random_limits(0, 12);
    queue_random_phase(250);
    settle();
    write_random_limits(0, 12);
    queue_random_phase(250);
    settle();

    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
